### design/sipq_pkg.sv
// shared types and constants for the sorted insert priority queue
`default_nettype none

package sipq_pkg;

  localparam int KEY_W     = 16;
  localparam int DATA_W    = 16;
  localparam int FILL_W    = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [KEY_W-1:0]   entry_key;
    logic [DATA_W-1:0]  entry_data;
  } sipq_req_t;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   head_key;
    logic [DATA_W-1:0]  head_data;
    logic [FILL_W-1:0]  fill_level;
  } sipq_rsp_t;

  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
  } sipq_ctrl_t;

endpackage

`default_nettype wire

### design/sipq_cell.sv
// one slot of the sorted chain: compares against the new key and shifts
`default_nettype none

module sipq_cell
  import sipq_pkg::*;
(
  input  wire logic              clk,
  input  wire sipq_ctrl_t        ctrl,
  input  wire logic              occupied,
  input  wire logic              left_gt,
  input  wire logic [KEY_W-1:0]  left_key,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [KEY_W-1:0]  right_key,
  input  wire logic [DATA_W-1:0] right_data,
  output logic                   gt,
  output logic [KEY_W-1:0]       key,
  output logic [DATA_W-1:0]      data
);

  logic [KEY_W-1:0]  key_next;
  logic [DATA_W-1:0] data_next;

  // empty slots count as greater so the new entry lands at the tail
  assign gt = !occupied || (key > ctrl.key);

  always_comb begin
    key_next  = key;
    data_next = data;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        key_next  = left_key;
        data_next = left_data;
      end else begin
        key_next  = ctrl.key;
        data_next = ctrl.data;
      end
    end else if (ctrl.rem) begin
      key_next  = right_key;
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    key  <= key_next;
    data <= data_next;
  end

endmodule

`default_nettype wire

### design/sorted_insert_priority_queue.sv
// top level: fill counter, row of sorted cells and registered result
// the result strobe is registered and comes in the cycle after the request is taken
// throughput: one request per cycle, every cell compares and shifts at once
// busy stays low; the receiver cannot stall and results are never held
// reset empties the queue (count to zero); slot contents are not cleared
`default_nettype none

module sorted_insert_priority_queue
  import sipq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire sipq_req_t request,
  output logic           result_valid,
  output sipq_rsp_t      result
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic              full;
  logic              empty;
  status_t           status_next;
  status_t           status;
  sipq_ctrl_t        ctrl;

  logic [DEPTH-1:0]  gt;
  logic [KEY_W-1:0]  keys  [DEPTH];
  logic [DATA_W-1:0] datas [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    ctrl.key    = request.entry_key;
    ctrl.data   = request.entry_data;
    count_next  = count;
    status_next = STAT_DONE;
    if (accept) begin
      case (request.operation)
        OP_INSERT: begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            ctrl.ins   = 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else begin
            ctrl.rem   = 1'b1;
            count_next = count - 1'b1;
          end
        end
        default: status_next = STAT_DONE;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              occ;
    logic              lgt;
    logic [KEY_W-1:0]  lkey;
    logic [DATA_W-1:0] ldata;
    logic [KEY_W-1:0]  rkey;
    logic [DATA_W-1:0] rdata;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lgt   = 1'b0;
      assign lkey  = request.entry_key;
      assign ldata = request.entry_data;
    end else begin : g_mid
      assign lgt   = gt[i-1];
      assign lkey  = keys[i-1];
      assign ldata = datas[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rkey  = keys[i];
      assign rdata = datas[i];
    end else begin : g_inner
      assign rkey  = keys[i+1];
      assign rdata = datas[i+1];
    end

    sipq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .left_gt    (lgt),
      .left_key   (lkey),
      .left_data  (ldata),
      .right_key  (rkey),
      .right_data (rdata),
      .gt         (gt[i]),
      .key        (keys[i]),
      .data       (datas[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      result_valid <= accept;
    end
    status <= status_next;
  end

  always_comb begin
    result.status     = status;
    result.fill_level = FILL_W'(count);
    if (count == '0) begin
      result.head_key  = '0;
      result.head_data = '0;
    end else begin
      result.head_key  = keys[0];
      result.head_data = datas[0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("result strobe missing after request");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && request.operation == OP_INSERT && full) |=>
      ($stable(count) && result.status == STAT_FULL))
    else $error("full insert changed the queue");

  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && request.operation == OP_REMOVE && empty) |=>
      (count == '0 && result.status == STAT_EMPTY))
    else $error("empty remove changed the queue");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the sorted insert priority queue
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sipq_pkg::*;

  localparam int QUEUE_DEPTH    = DEPTH_DEF;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 4;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  sipq_req_t request = '0;
  logic      busy;
  logic      result_valid;
  sipq_rsp_t result;

  logic [KEY_W-1:0]  mirror_key  [QUEUE_DEPTH];
  logic [DATA_W-1:0] mirror_data [QUEUE_DEPTH];
  int                mirror_count = 0;
  sipq_rsp_t         pending_results [$];
  int                mismatches   = 0;
  int                items_sent   = 0;
  int                idle_cycles  = 0;
  bit                idle_enabled = 1'b1;

  always #6 clk = ~clk;

  sorted_insert_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  function automatic string describe(input sipq_rsp_t r);
    return $sformatf("status=%0d key=%h data=%h fill=%0d",
                     r.status, r.head_key, r.head_data, r.fill_level);
  endfunction

  function automatic sipq_rsp_t predict_queue_result(input sipq_req_t req);
    sipq_rsp_t rsp;
    int        pos;
    rsp = '0;
    rsp.status = STAT_DONE;
    if (req.operation == OP_INSERT) begin
      if (mirror_count >= QUEUE_DEPTH) begin
        rsp.status = STAT_FULL;
      end else begin
        pos = mirror_count;
        for (int i = 0; i < mirror_count; i++) begin
          if (mirror_key[i] > req.entry_key) begin
            pos = i;
            break;
          end
        end
        for (int i = mirror_count; i > pos; i--) begin
          mirror_key[i]  = mirror_key[i-1];
          mirror_data[i] = mirror_data[i-1];
        end
        mirror_key[pos]  = req.entry_key;
        mirror_data[pos] = req.entry_data;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        rsp.status = STAT_EMPTY;
      end else begin
        for (int i = 1; i < mirror_count; i++) begin
          mirror_key[i-1]  = mirror_key[i];
          mirror_data[i-1] = mirror_data[i];
        end
        mirror_count--;
      end
    end
    if (mirror_count > 0) begin
      rsp.head_key  = mirror_key[0];
      rsp.head_data = mirror_data[0];
    end
    rsp.fill_level = FILL_W'(mirror_count);
    return rsp;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic check_result(input sipq_rsp_t got);
    sipq_rsp_t want;
    if (pending_results.size() == 0) begin
      note_mismatch({"result with no request pending: ", describe(got)});
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.head_key !== want.head_key ||
        got.head_data !== want.head_data || got.fill_level !== want.fill_level) begin
      note_mismatch({"expected ", describe(want), " got ", describe(got)});
    end
  endtask

  // result checking, request tracking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      mirror_count = 0;
      pending_results.delete();
      idle_cycles = 0;
    end else begin
      if (result_valid) begin
        check_result(result);
      end
      if (start && !busy) begin
        pending_results.push_back(predict_queue_result(request));
      end
      if (result_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] data);
    sipq_req_t req;
    int        gap;
    req.operation  = op;
    req.entry_key  = key;
    req.entry_data = data;
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_extreme_fields();
    send_request(OP_REMOVE, 16'hFFFF, 16'hFFFF);
    send_request(OP_INSERT, 16'hFFFF, 16'h0000);
    send_request(OP_INSERT, 16'h0000, 16'hFFFF);
    send_request(OP_INSERT, 16'h8000, 16'h1234);
    send_request(OP_INSERT, 16'h8000, 16'hABCD);
    send_request(OP_INSERT, 16'hFFFF, 16'h5A5A);
    send_request(OP_INSERT, 16'h0000, 16'h0001);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
    send_request(OP_REMOVE, 16'hFFFF, 16'hFFFF);
    send_request(OP_REMOVE, 16'h5555, 16'hAAAA);
    send_request(OP_REMOVE, 16'hAAAA, 16'h5555);
    send_request(OP_REMOVE, 16'h0000, 16'hFFFF);
    send_request(OP_REMOVE, 16'hFFFF, 16'h0000);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
  endtask

  task automatic test_fill_to_full();
    repeat (QUEUE_DEPTH) send_request(OP_INSERT, 16'($urandom), 16'($urandom));
    send_request(OP_INSERT, 16'h0000, 16'($urandom));
    send_request(OP_INSERT, 16'hFFFF, 16'($urandom));
    // hold off until the queue state is settled
    wait_until_drained();
    repeat (QUEUE_DEPTH) send_request(OP_REMOVE, 16'($urandom), 16'($urandom));
    send_request(OP_REMOVE, 16'($urandom), 16'($urandom));
    send_request(OP_REMOVE, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int style,
                                                input logic [KEY_W-1:0] base);
    case (style)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 2))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic test_random_mix();
    int               seg_len;
    int               ins_pct;
    int               style;
    logic [KEY_W-1:0] base;
    while (items_sent < 640) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0: ins_pct = 25;
        1: ins_pct = 50;
        default: ins_pct = 80;
      endcase
      style = $urandom_range(0, 2);
      base  = 16'($urandom);
      repeat (seg_len) begin
        send_request(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                     pick_key(style, base), 16'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
        wait_until_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_enabled = 1'b0;
    repeat (80) begin
      send_request($urandom_range(0, 1) ? OP_INSERT : OP_REMOVE,
                   pick_key($urandom_range(0, 2), 16'($urandom)), 16'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_fields();
    test_fill_to_full();
    test_random_mix();
    test_back_to_back();
    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
